### src/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

   // Default number of fraction bits in all fixed-point quantities.
   localparam int SKF_FRAC_BITS = 16;

   localparam int VAL_W      = 32;   // sample and estimate
   localparam int VAR_W      = 26;   // error variance
   localparam int NOISE_W    = 24;   // noise registers
   localparam int GAIN_OUT_W = 17;   // gain field of a result
   localparam int MAG_W      = VAL_W + 1;
   localparam int MUL_B_W    = 17;
   localparam int CSR_IDX_W  = 1;

   localparam logic [VAR_W-1:0]   VAR_MAX     = VAR_W'(1) << 25;
   localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROCESS_NOISE     = 1'b0,
      REG_MEASUREMENT_NOISE = 1'b1
   } skf_reg_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_PREDICT,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_MUL_DLO,
      CMD_MUL_DHI,
      CMD_MUL_PLO,
      CMD_MUL_PHI,
      CMD_VAR_FIN,
      CMD_EMIT
   } skf_cmd_type;

endpackage

### src/skf_ctrl.sv
`timescale 1ns / 1ps

module skf_ctrl import skf_pkg::*; #(
   parameter int FRAC_BITS = SKF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_op,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output skf_cmd_type cmd
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DINIT,
      ST_DSTEP,
      ST_MDLO,
      ST_MDHI,
      ST_MPLO,
      ST_MPHI,
      ST_VFIN,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             accept;
   logic             slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:  cmd = accept ? (req_op ? CMD_PREDICT : CMD_LOAD) : CMD_NONE;
         ST_DINIT: cmd = CMD_DIV_INIT;
         ST_DSTEP: cmd = CMD_DIV_STEP;
         ST_MDLO:  cmd = CMD_MUL_DLO;
         ST_MDHI:  cmd = CMD_MUL_DHI;
         ST_MPLO:  cmd = CMD_MUL_PLO;
         ST_MPHI:  cmd = CMD_MUL_PHI;
         ST_VFIN:  cmd = CMD_VAR_FIN;
         ST_EMIT:  cmd = slot_free ? CMD_EMIT : CMD_NONE;
         default:  cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_EMIT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= req_op ? ST_DINIT : ST_EMIT;
               end
            end
            ST_DINIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DSTEP;
            end
            ST_DSTEP: begin
               // One quotient bit per cycle; FRAC_BITS + 1 bits in all.
               if (cnt_ff == CNT_W'(FRAC_BITS)) begin
                  state_ff <= ST_MDLO;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_MDLO: state_ff <= ST_MDHI;
            ST_MDHI: state_ff <= ST_MPLO;
            ST_MPLO: state_ff <= ST_MPHI;
            ST_MPHI: state_ff <= ST_VFIN;
            ST_VFIN: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### src/skf_dpath.sv
`timescale 1ns / 1ps

module skf_dpath import skf_pkg::*; #(
   parameter int FRAC_BITS = SKF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [NOISE_W-1:0]      csr_wdata,
   input  skf_cmd_type             cmd,
   input  logic signed [VAL_W-1:0] req_sample,
   output logic signed [VAL_W-1:0] rsp_estimate,
   output logic [VAR_W-1:0]        rsp_variance,
   output logic [GAIN_OUT_W-1:0]   rsp_gain
);

   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int PROD_W = GAIN_W + MUL_B_W;
   localparam int ACC_W  = GAIN_W + MAG_W;
   localparam int DEN_W  = VAR_W + 1;

   localparam logic [GAIN_W-1:0] ONE_GAIN = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VAR_W-1:0]  VAR_ONE  = {{(VAR_W - GAIN_W){1'b0}}, ONE_GAIN};
   localparam logic [ACC_W-1:0]  HALF_ACC =
      {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [VAL_W+1:0] EST_HI = 34'sd2147483647;
   localparam logic signed [VAL_W+1:0] EST_LO = -34'sd2147483648;

   // Configuration and filter state.
   logic [NOISE_W-1:0]      q_ff;
   logic [NOISE_W-1:0]      r_ff;
   logic signed [VAL_W-1:0] est_ff;
   logic [VAR_W-1:0]        var_ff;

   // Working registers of one filter step.
   logic signed [VAL_W-1:0] sample_ff;
   logic [VAR_W-1:0]        p_ff;
   logic [DEN_W-1:0]        den_ff;
   logic                    den_zero_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [GAIN_W-1:0]       num_ff;
   logic [GAIN_W-1:0]       quot_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic                    neg_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic signed [VAL_W+1:0] step_ff;
   logic [GAIN_OUT_W-1:0]   gain_res_ff;

   logic signed [VAL_W-1:0] out_est_ff;
   logic [VAR_W-1:0]        out_var_ff;
   logic [GAIN_OUT_W-1:0]   out_gain_ff;

   logic [DEN_W-1:0]        pred_sum;
   logic [VAR_W-1:0]        p_in;
   logic [DEN_W-1:0]        den_sum;
   logic [DEN_W-1:0]        rem_shift;
   logic                    rem_ge;
   logic [DEN_W-1:0]        rem_sub;
   logic [GAIN_W-1:0]       gain;
   logic [MAG_W-1:0]        diff;
   logic [MAG_W-1:0]        mag_in;
   logic [GAIN_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [PROD_W-1:0]       prod;
   logic [ACC_W-1:0]        rnd;
   logic [ACC_W-1:0]        rnd_sh;
   logic [MAG_W-1:0]        step_mag;
   logic signed [VAL_W+1:0] step_in;
   logic signed [VAL_W+1:0] est_sum;
   logic signed [VAL_W-1:0] est_in;
   logic [DEN_W-1:0]        var_rnd;
   logic [VAR_W-1:0]        var_in;

   // Prediction: P + q, saturated.
   assign pred_sum = {1'b0, var_ff} + {{(DEN_W - NOISE_W){1'b0}}, q_ff};
   assign p_in     = (pred_sum > {1'b0, VAR_MAX}) ? VAR_MAX : pred_sum[VAR_W-1:0];
   assign den_sum  = {1'b0, p_ff} + {{(DEN_W - NOISE_W){1'b0}}, r_ff};

   // Restoring division step. The remainder always stays below a nonzero divisor.
   assign rem_shift = {rem_ff[DEN_W-2:0], num_ff[GAIN_W-1]};
   assign rem_ge    = (rem_shift >= den_ff);
   assign rem_sub   = rem_shift - den_ff;
   assign gain      = den_zero_ff ? '0 : quot_ff;

   // Innovation as sign and magnitude.
   assign diff   = {sample_ff[VAL_W-1], sample_ff} - {est_ff[VAL_W-1], est_ff};
   assign mag_in = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

   always_comb begin
      case (cmd)
         CMD_MUL_DLO: begin
            mul_a = gain;
            mul_b = {1'b0, mag_ff[15:0]};
         end
         CMD_MUL_DHI: begin
            mul_a = gain;
            mul_b = mag_ff[MAG_W-1:16];
         end
         CMD_MUL_PLO: begin
            mul_a = ONE_GAIN - gain;
            mul_b = {1'b0, p_ff[15:0]};
         end
         CMD_MUL_PHI: begin
            mul_a = ONE_GAIN - gain;
            mul_b = {{(MUL_B_W - (VAR_W - 16)){1'b0}}, p_ff[VAR_W-1:16]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Rounding of the accumulated product; used for the step and the variance.
   assign rnd      = acc_ff + HALF_ACC;
   assign rnd_sh   = rnd >> FRAC_BITS;
   assign step_mag = rnd_sh[MAG_W-1:0];
   assign step_in  = neg_ff ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});

   assign est_sum = $signed({{2{est_ff[VAL_W-1]}}, est_ff}) + step_ff;
   assign est_in  = (est_sum > EST_HI) ? 32'sh7fffffff :
                    (est_sum < EST_LO) ? 32'sh80000000 : est_sum[VAL_W-1:0];

   assign var_rnd = rnd_sh[DEN_W-1:0];
   assign var_in  = (var_rnd > {1'b0, VAR_MAX}) ? VAR_MAX : var_rnd[VAR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= NOISE_RESET;
         r_ff   <= NOISE_RESET;
         est_ff <= '0;
         var_ff <= VAR_ONE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PROCESS_NOISE:     q_ff <= csr_wdata;
               REG_MEASUREMENT_NOISE: r_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (cmd)
            CMD_LOAD: begin
               est_ff <= req_sample;
               var_ff <= VAR_ONE;
            end
            CMD_MUL_PHI: est_ff <= est_in;
            CMD_VAR_FIN: var_ff <= var_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            gain_res_ff <= '0;
         end
         CMD_PREDICT: begin
            sample_ff <= req_sample;
            p_ff      <= p_in;
         end
         CMD_DIV_INIT: begin
            // The top 25 numerator bits never reach the divisor, since P <= P + R.
            den_ff      <= den_sum;
            den_zero_ff <= (den_sum == '0);
            rem_ff      <= {2'b00, p_ff[VAR_W-1:1]};
            num_ff      <= {p_ff[0], {FRAC_BITS{1'b0}}};
            quot_ff     <= '0;
            mag_ff      <= mag_in;
            neg_ff      <= diff[MAG_W-1];
         end
         CMD_DIV_STEP: begin
            rem_ff  <= rem_ge ? rem_sub : rem_shift;
            quot_ff <= {quot_ff[GAIN_W-2:0], rem_ge};
            num_ff  <= num_ff << 1;
         end
         CMD_MUL_DLO: begin
            acc_ff      <= ACC_W'(prod);
            gain_res_ff <= GAIN_OUT_W'(gain);
         end
         CMD_MUL_DHI: begin
            acc_ff <= acc_ff + (ACC_W'(prod) << 16);
         end
         CMD_MUL_PLO: begin
            step_ff <= step_in;
            acc_ff  <= ACC_W'(prod);
         end
         CMD_MUL_PHI: begin
            acc_ff <= acc_ff + (ACC_W'(prod) << 16);
         end
         CMD_EMIT: begin
            out_est_ff  <= est_ff;
            out_var_ff  <= var_ff;
            out_gain_ff <= gain_res_ff;
         end
         default: ;
      endcase
   end

   assign rsp_estimate = out_est_ff;
   assign rsp_variance = out_var_ff;
   assign rsp_gain     = out_gain_ff;

endmodule

### src/scalar_kalman_filter.sv
`timescale 1ns / 1ps

// One-dimensional Kalman filter in fixed point with FRAC_BITS fraction bits.
// A load item (op 0) sets the estimate to the sample and the variance to 1.0;
// a filter item (op 1) predicts, forms the gain with a restoring divider that
// produces one quotient bit per cycle, and updates estimate and variance with
// a shared multiplier on the low and high halves of the innovation magnitude
// and then of the predicted variance. Each item yields one result. The next
// item is taken once the current result is written to the output register (a
// write that waits while an earlier one is unread), where it may still wait.
// Noise registers are to be written through the csr_ port only while the
// block is idle; the block itself does not enforce this.
module scalar_kalman_filter import skf_pkg::*; #(
   parameter int FRAC_BITS = SKF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [NOISE_W-1:0]      csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic signed [VAL_W-1:0] req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_estimate,
   output logic [VAR_W-1:0]        rsp_variance,
   output logic [GAIN_OUT_W-1:0]   rsp_gain
);

   skf_cmd_type cmd;

   skf_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   skf_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .rsp_estimate (rsp_estimate),
      .rsp_variance (rsp_variance),
      .rsp_gain     (rsp_gain)
   );

   // After an input transfer the block is busy in the following cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after a transfer");

   // A result appears only through the emit command.
   a_valid_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd == CMD_EMIT))
      else $error("result valid without emit");

   // A delivered variance never exceeds the saturation limit.
   a_variance_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_variance <= VAR_MAX))
      else $error("variance above limit");

endmodule
